// ----- hdl/wsd_pkg.sv -----
// shared types and constants for the websocket frame deframer
// no dependencies; imported by wsd_core, wsd_out_reg and websocket_frame_deframer
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // header decode constants
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [2:0] LEN16_BYTES = 3'd2;

    localparam int REM_W = 64;

    // parser phases, one-hot
    typedef enum logic [6:0] {
        ST_START = 7'b0000001,
        ST_LEN   = 7'b0000010,
        ST_LEN16 = 7'b0000100,
        ST_LEN64 = 7'b0001000,
        ST_KEY   = 7'b0010000,
        ST_DATA  = 7'b0100000,
        ST_ERR   = 7'b1000000
    } t_state;

    // one result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       frame_last;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/websocket_frame_deframer.sv -----
// top level of the websocket client-to-server frame deframer
// depends on wsd_pkg, wsd_core and wsd_out_reg
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   handshake            payload
// input     in    i_valid / o_ready    i_rx_byte
// result    out   o_valid / i_ready    o_kind, o_payload_byte, o_frame_opcode, o_frame_last
//
// one byte is taken per cycle while o_ready is high; each byte yields zero or one result item
// a result appears on the outputs in the cycle after its byte is accepted
// o_ready is low while a result waits in the output register with i_ready low,
// so a stalled result holds the input even when the next byte yields nothing
// i_rst_n is synchronous, active low; it returns the parser to header
// parsing and clears the mask key, the length and the error lock
// after a protocol error (mask bit clear) all bytes are taken and dropped

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte input
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    // result output
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_payload_byte,
    output logic [3:0]      o_frame_opcode,
    output logic            o_frame_last
);

    logic    take;
    logic    free;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // a byte moves when the result side can hold whatever it produces
    assign o_ready = free;
    assign take    = i_valid && free;

    // header parse, key capture and unmasking
    wsd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // registered result stage
    wsd_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_payload_byte = out_res.payload_byte;
    assign o_frame_opcode = out_res.frame_opcode;
    assign o_frame_last   = out_res.frame_last;

endmodule

`default_nettype wire

// ----- hdl/wsd_core.sv -----
// header parser, mask key store and payload unmasking for one byte per cycle while i_take is high
// depends on wsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsd_core
    import wsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_res_valid,
    output t_result         o_res
);

    t_state             r_state, n_state;
    logic [7:0]         r_key [4];
    logic [7:0]         n_key [4];
    logic [1:0]         r_key_idx, n_key_idx;
    logic [2:0]         r_len_cnt, n_len_cnt;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [3:0]         r_opcode, n_opcode;
    logic [1:0]         r_pay_idx, n_pay_idx;

    logic [2:0]         len_cnt_inc;
    logic [REM_W-1:0]   rem_dec;

    assign len_cnt_inc = r_len_cnt + 3'd1;
    assign rem_dec     = r_rem - {{(REM_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_key_idx = r_key_idx;
        n_len_cnt = r_len_cnt;
        n_rem     = r_rem;
        n_opcode  = r_opcode;
        n_pay_idx = r_pay_idx;

        o_res_valid        = 1'b0;
        o_res              = '0;
        o_res.frame_opcode = r_opcode;

        case (r_state)
            ST_START: begin
                n_opcode = i_rx_byte[3:0];
                n_state  = ST_LEN;
            end
            ST_LEN: begin
                if (!i_rx_byte[7]) begin
                    // mask bit clear: report once and lock up
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                    n_state     = ST_ERR;
                end else begin
                    n_len_cnt = '0;
                    if (i_rx_byte[6:0] == LEN_CODE_16) begin
                        n_rem   = '0;
                        n_state = ST_LEN16;
                    end else if (i_rx_byte[6:0] == LEN_CODE_64) begin
                        n_rem   = '0;
                        n_state = ST_LEN64;
                    end else begin
                        n_rem     = {{(REM_W-7){1'b0}}, i_rx_byte[6:0]};
                        n_key_idx = '0;
                        n_state   = ST_KEY;
                    end
                end
            end
            ST_LEN16, ST_LEN64: begin
                n_rem     = {r_rem[REM_W-9:0], i_rx_byte};
                n_len_cnt = len_cnt_inc;
                if ((r_state == ST_LEN16 && len_cnt_inc == LEN16_BYTES) ||
                    (r_state == ST_LEN64 && len_cnt_inc == 3'd0)) begin
                    n_len_cnt = '0;
                    n_key_idx = '0;
                    n_state   = ST_KEY;
                end
            end
            ST_KEY: begin
                n_key[r_key_idx] = i_rx_byte;
                n_key_idx        = r_key_idx + 2'd1;
                if (r_key_idx == 2'd3) begin
                    n_pay_idx = '0;
                    if (r_rem == '0) begin
                        // empty frame ends right after the key
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_EMPTY;
                        o_res.frame_last = 1'b1;
                        n_state          = ST_START;
                        n_key_idx        = '0;
                        n_len_cnt        = '0;
                        n_rem            = '0;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_PAYLOAD;
                o_res.payload_byte = i_rx_byte ^ r_key[r_pay_idx];
                n_pay_idx          = r_pay_idx + 2'd1;
                n_rem              = rem_dec;
                if (rem_dec == '0) begin
                    o_res.frame_last = 1'b1;
                    n_state          = ST_START;
                    n_key_idx        = '0;
                    n_len_cnt        = '0;
                    n_pay_idx        = '0;
                end
            end
            ST_ERR: begin
                // bytes dropped until reset
            end
            default: begin
                n_state   = ST_START;
                n_key_idx = '0;
                n_len_cnt = '0;
                n_rem     = '0;
                n_pay_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_START;
            r_key     <= '{default: '0};
            r_key_idx <= '0;
            r_len_cnt <= '0;
            r_rem     <= '0;
            r_opcode  <= '0;
            r_pay_idx <= '0;
        end else if (i_take) begin
            r_state   <= n_state;
            r_key     <= n_key;
            r_key_idx <= n_key_idx;
            r_len_cnt <= n_len_cnt;
            r_rem     <= n_rem;
            r_opcode  <= n_opcode;
            r_pay_idx <= n_pay_idx;
        end
    end

    // error result locks the parser
    a_err_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_res_valid && o_res.kind == KIND_ERROR) |=> r_state == ST_ERR)
        else $error("error result did not lock the parser");

    // nothing comes out once locked
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ERR |-> !o_res_valid)
        else $error("result produced while in error");

    // the last result of a frame returns to header parsing
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && o_res_valid && o_res.frame_last) |=> r_state == ST_START)
        else $error("frame end did not restart header parsing");

    // a data phase always has bytes left
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DATA |-> r_rem != '0)
        else $error("data phase with zero remaining length");

endmodule

`default_nettype wire

// ----- hdl/wsd_out_reg.sv -----
// output register for result items, decouples the parser from downstream stalls
// depends on wsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsd_out_reg
    import wsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_take,
    input  wire logic    i_res_valid,
    input  wire t_result i_res,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    // room when empty or when the held item leaves this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_websocket_frame_deframer.sv -----
// self-checking testbench for websocket_frame_deframer: random framed byte streams in,
// unmasked payload, empty-frame and error items checked against an in-bench parser model
// depends on wsd_pkg and websocket_frame_deframer
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
    import wsd_pkg::*;

    localparam int RANDOM_ITEMS   = 250;
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES   = 16;    // results come out of a single output register, so this is ample
    localparam int MAX_REPORTS    = 40;    // mismatches past this are counted, not printed

    // how the payload length is encoded in the header
    typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} t_len_form;

    // receiver back-pressure styles, switched every so often
    typedef enum {RX_FULL, RX_RANDOM, RX_PATTERN, RX_BURSTY} t_rx_mode;

    // one stream byte; hold_off makes the sender wait until all results are back
    typedef struct {
        logic [7:0] b;
        bit         hold_off;
    } t_rx_item;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_payload_byte;
    logic [3:0] o_frame_opcode;
    logic       o_frame_last;

    websocket_frame_deframer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_frame_opcode (o_frame_opcode),
        .o_frame_last   (o_frame_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_rx_item stream_bytes[$];      // bytes waiting to be sent
    t_result  expected_results[$];  // results owed by the block, oldest first
    int       results_due   = 0;    // registered copy of the queue depth for the sender
    int       mismatch_count = 0;
    int       result_count  = 0;
    int       idle_cycles   = 0;

    // ------------------------------------------------------------------
    // parser model: mirrors the deframer state one accepted byte at a time
    // ------------------------------------------------------------------
    t_state      parse_phase  = ST_START;
    logic [7:0]  mask_bytes [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    logic [1:0]  key_pos      = 2'd0;
    logic [2:0]  ext_len_cnt  = 3'd0;
    logic [63:0] bytes_left   = 64'd0;
    logic [3:0]  frame_op     = 4'd0;
    logic [1:0]  unmask_pos   = 2'd0;

    task automatic parse_rx_byte(input logic [7:0] b);
        t_result r;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = 8'h00;
        r.frame_opcode = frame_op;
        r.frame_last   = 1'b0;
        case (parse_phase)
            ST_START: begin
                // flag bits are dropped, only the opcode nibble survives
                frame_op    = b[3:0];
                parse_phase = ST_LEN;
            end
            ST_LEN: begin
                if (!b[7]) begin
                    // client frames must be masked: report once and lock up
                    r.kind      = KIND_ERROR;
                    parse_phase = ST_ERR;
                    expected_results.push_back(r);
                end else begin
                    ext_len_cnt = 3'd0;
                    if (b[6:0] == LEN_CODE_16) begin
                        bytes_left  = 64'd0;
                        parse_phase = ST_LEN16;
                    end else if (b[6:0] == LEN_CODE_64) begin
                        bytes_left  = 64'd0;
                        parse_phase = ST_LEN64;
                    end else begin
                        bytes_left  = {57'd0, b[6:0]};
                        key_pos     = 2'd0;
                        parse_phase = ST_KEY;
                    end
                end
            end
            ST_LEN16, ST_LEN64: begin
                bytes_left  = {bytes_left[55:0], b};
                ext_len_cnt = ext_len_cnt + 3'd1;
                // 64-bit length is done when the 3-bit count wraps
                if ((parse_phase == ST_LEN16 && ext_len_cnt == LEN16_BYTES) ||
                    (parse_phase == ST_LEN64 && ext_len_cnt == 3'd0)) begin
                    ext_len_cnt = 3'd0;
                    key_pos     = 2'd0;
                    parse_phase = ST_KEY;
                end
            end
            ST_KEY: begin
                mask_bytes[key_pos] = b;
                key_pos = key_pos + 2'd1;
                if (key_pos == 2'd0) begin
                    unmask_pos = 2'd0;
                    if (bytes_left == 64'd0) begin
                        // empty frame closes right after the key
                        r.kind       = KIND_EMPTY;
                        r.frame_last = 1'b1;
                        expected_results.push_back(r);
                        parse_phase = ST_START;
                    end else begin
                        parse_phase = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                r.payload_byte = b ^ mask_bytes[unmask_pos];
                unmask_pos = unmask_pos + 2'd1;
                bytes_left = bytes_left - 64'd1;
                if (bytes_left == 64'd0) begin
                    r.frame_last = 1'b1;
                    parse_phase  = ST_START;
                    key_pos      = 2'd0;
                    unmask_pos   = 2'd0;
                end
                expected_results.push_back(r);
            end
            ST_ERR: begin
                // locked: everything is swallowed
            end
            default: parse_phase = ST_START;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic queue_frame(input logic [7:0] hdr, input t_len_form form,
                               input logic [63:0] plen, input logic [31:0] key,
                               input bit hold_off);
        longint unsigned n;
        stream_bytes.push_back('{hdr, hold_off});
        case (form)
            LEN_SHORT: stream_bytes.push_back('{{1'b1, plen[6:0]}, 1'b0});
            LEN_EXT16: begin
                stream_bytes.push_back('{{1'b1, LEN_CODE_16}, 1'b0});
                stream_bytes.push_back('{plen[15:8], 1'b0});
                stream_bytes.push_back('{plen[7:0], 1'b0});
            end
            default: begin
                stream_bytes.push_back('{{1'b1, LEN_CODE_64}, 1'b0});
                for (int i = 7; i >= 0; i--)
                    stream_bytes.push_back('{plen[8*i +: 8], 1'b0});
            end
        endcase
        for (int i = 3; i >= 0; i--)
            stream_bytes.push_back('{key[8*i +: 8], 1'b0});
        for (n = 0; n < plen; n++)
            stream_bytes.push_back('{8'($urandom_range(0, 255)), 1'b0});
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_rx_item item;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_rx_byte  <= 8'h00;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!i_valid || o_ready) begin
            // the slot is free after this edge: either empty or just taken
            if (gap_left != 0) begin
                i_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (stream_bytes.size() == 0) begin
                i_valid <= 1'b0;
            end else if (stream_bytes[0].hold_off && (i_valid || results_due != 0)) begin
                // pause until every owed result has been drained
                i_valid <= 1'b0;
            end else begin
                item = stream_bytes.pop_front();
                i_valid   <= 1'b1;
                i_rx_byte <= item.b;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    // a quarter of bursts run straight into the next one
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver back-pressure, its mode is redrawn at random when its countdown runs out
    // ------------------------------------------------------------------
    t_rx_mode   rx_mode    = RX_FULL;
    int         mode_left  = 0;
    int         stall_left = 0;
    logic [7:0] stall_pat  = 8'b1011_0010;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            rx_mode    <= RX_FULL;
            mode_left  <= 0;
            stall_left <= 0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= t_rx_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(50, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_FULL:   i_ready <= 1'b1;
                RX_RANDOM: i_ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: begin
                    i_ready   <= stall_pat[0];
                    stall_pat <= {stall_pat[0], stall_pat[7:1]};
                end
                default: begin
                    // long stalls broken by short ready windows
                    if (stall_left == 0) begin
                        i_ready    <= ~i_ready;
                        stall_left <= i_ready ? $urandom_range(5, 40) : $urandom_range(1, 4);
                    end else begin
                        stall_left <= stall_left - 1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: check results first, then feed the accepted byte to the model
    // (a result can never come from the byte taken at the same edge)
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d byte %02h op %0h last %0b",
                                              o_kind, o_payload_byte, o_frame_opcode,
                                              o_frame_last));
                end else begin
                    want = expected_results.pop_front();
                    if (o_kind !== want.kind)
                        report_mismatch($sformatf("result %0d kind %0d, want %0d",
                                                  result_count, o_kind, want.kind));
                    if (o_payload_byte !== want.payload_byte)
                        report_mismatch($sformatf("result %0d payload %02h, want %02h",
                                                  result_count, o_payload_byte,
                                                  want.payload_byte));
                    if (o_frame_opcode !== want.frame_opcode)
                        report_mismatch($sformatf("result %0d opcode %0h, want %0h",
                                                  result_count, o_frame_opcode,
                                                  want.frame_opcode));
                    if (o_frame_last !== want.frame_last)
                        report_mismatch($sformatf("result %0d last %0b, want %0b",
                                                  result_count, o_frame_last,
                                                  want.frame_last));
                end
                result_count++;
            end
            if (i_valid && o_ready)
                parse_rx_byte(i_rx_byte);
            results_due <= expected_results.size();
            if ((o_valid && i_ready) || (i_valid && o_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog: nothing moved for too long
    always @(negedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int          first;
        int          pick;
        logic [7:0]  hdr;
        logic [63:0] plen;
        t_len_form   form;

        // directed: all-ones header with a non-minimal 64-bit length of one
        queue_frame(8'hFF, LEN_EXT64, 64'd1, 32'h0000_0000, 1'b0);
        // directed: empty close frame with an all-ones key
        queue_frame(8'h88, LEN_SHORT, 64'd0, 32'hFFFF_FFFF, 1'b0);

        // random well-formed frames with random flags, opcodes and encodings
        first = stream_bytes.size();
        while (stream_bytes.size() - first < RANDOM_ITEMS) begin
            hdr = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                hdr[3:0] = 4'($urandom_range(8, 10));  // close, ping, pong
            pick = $urandom_range(0, 99);
            form = LEN_SHORT;
            if (pick < 15) begin
                plen = 64'd0;
            end else if (pick < 70) begin
                plen = 64'($urandom_range(1, 12));
            end else if (pick < 75) begin
                plen = 64'($urandom_range(120, 125));
            end else if (pick < 88) begin
                form = LEN_EXT16;
                plen = 64'($urandom_range(0, 40));
            end else if (pick < 92) begin
                form = LEN_EXT16;
                plen = 64'($urandom_range(126, 200));
            end else begin
                form = LEN_EXT64;
                plen = 64'($urandom_range(0, 16));
            end
            queue_frame(hdr, form, plen, $urandom, $urandom_range(0, 19) == 0);
        end

        // 16-bit length with the high byte set, started from a drained block
        queue_frame(8'h82, LEN_EXT16, 64'h0101, $urandom, 1'b1);
        queue_frame(8'($urandom_range(0, 255)), LEN_SHORT, 64'd2, $urandom, 1'b0);

        // mask bit clear: one error item, then everything after is dropped
        stream_bytes.push_back('{8'h89, 1'b1});
        stream_bytes.push_back('{{1'b0, 7'($urandom_range(0, 127))}, 1'b0});
        for (int i = 0; i < 10; i++)
            stream_bytes.push_back('{8'($urandom_range(0, 255)), 1'b0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stream_bytes.size() != 0 || i_valid)
            @(negedge i_clk);
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/wsd_pkg.sv
hdl/wsd_core.sv
hdl/wsd_out_reg.sv
hdl/websocket_frame_deframer.sv
tb/sv/tb_websocket_frame_deframer.sv
